// File: src/lrfe_pkg.sv
// ----------------------------------------------------------------------------
// Log ring package
// Sizes, codes, item types and shared pointer arithmetic for the log ring.
// ----------------------------------------------------------------------------
package lrfe_pkg;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned ENTRY_WIDTH = 32;

  localparam int unsigned PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W     = CNT_W + 1;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned XCNT_W    = 10;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_THRESH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_BATCH = 2'd2;

  localparam logic [CFG_W-1:0] RST_RING_SIZE   = 7'd64;
  localparam logic [CFG_W-1:0] RST_FLUSH_THRESH = 7'd32;
  localparam logic [CFG_W-1:0] RST_FLUSH_BATCH = 7'd16;

  // Operation codes.
  localparam logic [2:0] OP_PUSH          = 3'd0;
  localparam logic [2:0] OP_FLUSH_START   = 3'd1;
  localparam logic [2:0] OP_FLUSH_DONE    = 3'd2;
  localparam logic [2:0] OP_EXPORT_BEGIN  = 3'd3;
  localparam logic [2:0] OP_EXPORT_COMMIT = 3'd4;
  localparam logic [2:0] OP_EXPORT_ABORT  = 3'd5;

  // Storage outcome codes.
  localparam logic [1:0] SS_OK       = 2'd0;
  localparam logic [1:0] SS_NO_SPACE = 2'd1;

  // Result status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_DROPPED     = 3'd1;
  localparam logic [2:0] ST_BUSY        = 3'd2;
  localparam logic [2:0] ST_NOT_READY   = 3'd3;
  localparam logic [2:0] ST_INVALID     = 3'd4;
  localparam logic [2:0] ST_IO          = 3'd5;
  localparam logic [2:0] ST_FULL        = 3'd6;
  localparam logic [2:0] ST_STORAGE_ERR = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] entry_data;
    logic [1:0]  storage_status;
    logic        flash_has_entries;
    logic [9:0]  flash_entries;
    logic [9:0]  capacity_entries;
    logic        block_freed;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_entry;
    logic        entry_valid;
    logic        last;
    logic        flush_wanted;
    logic        retry_later;
    logic [6:0]  ram_count;
    logic        storage_full;
  } out_item_t;

  // What the control decided for one accepted request.
  typedef struct packed {
    logic             emit;
    logic [2:0]       status;
    logic             retry;
    logic [PTR_W-1:0] start_ptr;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic             flush_wanted;
    logic [6:0]       ram_count;
    logic             storage_full;
    logic [CNT_W-1:0] size;
  } flags_t;

  typedef struct packed {
    logic                   en;
    logic [PTR_W-1:0]       addr;
    logic [ENTRY_WIDTH-1:0] data;
  } ram_wr_t;

  // Advance a ring pointer by n slots, n never above the ring size.
  function automatic logic [PTR_W-1:0] adv_ptr(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] n,
                                               input logic [CNT_W-1:0] size);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(p) + SUM_W'(n);
    if (sum >= SUM_W'(size)) begin
      sum = sum - SUM_W'(size);
    end
    return PTR_W'(sum);
  endfunction

endpackage

// File: src/lrfe_in_if.sv
// ----------------------------------------------------------------------------
// Log ring request channel
// Valid/ready channel that carries one request item.
// ----------------------------------------------------------------------------
interface lrfe_in_if;
  import lrfe_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/lrfe_out_if.sv
// ----------------------------------------------------------------------------
// Log ring result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface lrfe_out_if;
  import lrfe_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/lrfe_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module lrfe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/lrfe_ctrl.sv
// ----------------------------------------------------------------------------
// Log ring control
// Pointers, fill level, reservations and configuration; decides each request.
// ----------------------------------------------------------------------------
module lrfe_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lrfe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lrfe_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            accept_i,
  input  lrfe_pkg::in_item_t              item_i,
  output lrfe_pkg::cmd_t                  cmd_o,
  output lrfe_pkg::flags_t                flags_o,
  output lrfe_pkg::ram_wr_t               wr_o
);
  import lrfe_pkg::*;

  logic [CFG_W-1:0]  ring_size_q, ring_size_d;
  logic [CFG_W-1:0]  thresh_q, thresh_d;
  logic [CFG_W-1:0]  batch_q, batch_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              flush_act_q, flush_act_d;
  logic [PTR_W-1:0]  flush_start_q, flush_start_d;
  logic              exp_act_q, exp_act_d;
  logic              exp_flash_q, exp_flash_d;
  logic [XCNT_W-1:0] exp_cnt_q, exp_cnt_d;
  logic              nvm_full_q, nvm_full_d;

  logic [CNT_W-1:0]  size;
  logic              ring_full;
  logic              reserved;
  logic [XCNT_W-1:0] flash_n;
  logic [CNT_W-1:0]  ring_n;
  logic [2:0]        storage_err;

  always_comb begin
    if (ring_size_q == '0) begin
      size = CNT_W'(1);
    end else if (ring_size_q > CFG_W'(DEPTH)) begin
      size = CNT_W'(DEPTH);
    end else begin
      size = CNT_W'(ring_size_q);
    end
  end

  assign ring_full   = (fill_q >= size);
  assign reserved    = flush_act_q || exp_act_q;
  assign storage_err = (item_i.storage_status == SS_NO_SPACE) ? ST_FULL : ST_STORAGE_ERR;
  assign flash_n     = (item_i.flash_entries < item_i.capacity_entries) ?
                       item_i.flash_entries : item_i.capacity_entries;
  // The capacity only wins when it is below the fill, so it fits the count.
  assign ring_n      = (XCNT_W'(fill_q) < item_i.capacity_entries) ?
                       fill_q : CNT_W'(item_i.capacity_entries);

  always_comb begin
    ring_size_d   = ring_size_q;
    thresh_d      = thresh_q;
    batch_d       = batch_q;
    rd_ptr_d      = rd_ptr_q;
    wr_ptr_d      = wr_ptr_q;
    fill_d        = fill_q;
    flush_act_d   = flush_act_q;
    flush_start_d = flush_start_q;
    exp_act_d     = exp_act_q;
    exp_flash_d   = exp_flash_q;
    exp_cnt_d     = exp_cnt_q;
    nvm_full_d    = nvm_full_q;

    cmd_o.emit      = 1'b0;
    cmd_o.status    = ST_OK;
    cmd_o.retry     = 1'b0;
    cmd_o.start_ptr = rd_ptr_q;
    cmd_o.count     = '0;

    wr_o.en   = 1'b0;
    wr_o.addr = wr_ptr_q;
    wr_o.data = ENTRY_WIDTH'(item_i.entry_data);

    if (accept_i) begin
      unique case (item_i.op)
        OP_PUSH: begin
          if (ring_full && reserved) begin
            cmd_o.status = ST_DROPPED;
          end else begin
            wr_o.en  = 1'b1;
            wr_ptr_d = adv_ptr(wr_ptr_q, CNT_W'(1), size);
            if (ring_full) begin
              rd_ptr_d = adv_ptr(rd_ptr_q, CNT_W'(1), size);
            end else begin
              fill_d = fill_q + CNT_W'(1);
            end
          end
        end
        OP_FLUSH_START: begin
          if (reserved) begin
            cmd_o.status = ST_BUSY;
          end else if (batch_q == '0 || CFG_W'(fill_q) < thresh_q ||
                       CFG_W'(fill_q) < batch_q) begin
            cmd_o.status = ST_NOT_READY;
          end else begin
            cmd_o.emit    = 1'b1;
            cmd_o.count   = CNT_W'(batch_q);
            flush_act_d   = 1'b1;
            flush_start_d = rd_ptr_q;
          end
        end
        OP_FLUSH_DONE: begin
          if (!flush_act_q) begin
            cmd_o.status = ST_INVALID;
          end else begin
            flush_act_d = 1'b0;
            if (item_i.storage_status == SS_OK) begin
              if (rd_ptr_q == flush_start_q && CFG_W'(fill_q) >= batch_q) begin
                rd_ptr_d = adv_ptr(rd_ptr_q, CNT_W'(batch_q), size);
                fill_d   = fill_q - CNT_W'(batch_q);
              end else begin
                cmd_o.status = ST_IO;
              end
            end else if (item_i.storage_status == SS_NO_SPACE) begin
              nvm_full_d   = 1'b1;
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.retry  = 1'b1;
              cmd_o.status = ST_STORAGE_ERR;
            end
          end
        end
        OP_EXPORT_BEGIN: begin
          if (item_i.capacity_entries == '0) begin
            cmd_o.status = ST_OK;
          end else if (item_i.storage_status != SS_OK) begin
            cmd_o.status = storage_err;
          end else if (reserved) begin
            cmd_o.status = ST_BUSY;
          end else if (item_i.flash_has_entries) begin
            if (flash_n == '0) begin
              cmd_o.status = ST_IO;
            end else begin
              exp_act_d   = 1'b1;
              exp_flash_d = 1'b1;
              exp_cnt_d   = flash_n;
            end
          end else if (ring_n != '0) begin
            cmd_o.emit  = 1'b1;
            cmd_o.count = ring_n;
            exp_act_d   = 1'b1;
            exp_flash_d = 1'b0;
            exp_cnt_d   = XCNT_W'(ring_n);
          end
        end
        OP_EXPORT_COMMIT: begin
          if (!exp_act_q) begin
            cmd_o.status = ST_INVALID;
          end else if (exp_flash_q) begin
            if (item_i.storage_status != SS_OK) begin
              cmd_o.status = storage_err;
            end else if (item_i.block_freed) begin
              nvm_full_d = 1'b0;
            end
          end else if (exp_cnt_q <= XCNT_W'(fill_q)) begin
            rd_ptr_d = adv_ptr(rd_ptr_q, CNT_W'(exp_cnt_q), size);
            fill_d   = fill_q - CNT_W'(exp_cnt_q);
          end else begin
            cmd_o.status = ST_INVALID;
          end
          exp_act_d   = 1'b0;
          exp_flash_d = 1'b0;
          exp_cnt_d   = '0;
        end
        OP_EXPORT_ABORT: begin
          exp_act_d   = 1'b0;
          exp_flash_d = 1'b0;
          exp_cnt_d   = '0;
        end
        default: begin
          cmd_o.status = ST_INVALID;
        end
      endcase
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RING_SIZE: begin
          // A new size empties the ring.
          ring_size_d   = cfg_data_i;
          rd_ptr_d      = '0;
          wr_ptr_d      = '0;
          fill_d        = '0;
          flush_start_d = '0;
        end
        CFG_FLUSH_THRESH: thresh_d = cfg_data_i;
        CFG_FLUSH_BATCH:  batch_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size_q   <= RST_RING_SIZE;
      thresh_q      <= RST_FLUSH_THRESH;
      batch_q       <= RST_FLUSH_BATCH;
      rd_ptr_q      <= '0;
      wr_ptr_q      <= '0;
      fill_q        <= '0;
      flush_act_q   <= 1'b0;
      flush_start_q <= '0;
      exp_act_q     <= 1'b0;
      exp_flash_q   <= 1'b0;
      exp_cnt_q     <= '0;
      nvm_full_q    <= 1'b0;
    end else begin
      ring_size_q   <= ring_size_d;
      thresh_q      <= thresh_d;
      batch_q       <= batch_d;
      rd_ptr_q      <= rd_ptr_d;
      wr_ptr_q      <= wr_ptr_d;
      fill_q        <= fill_d;
      flush_act_q   <= flush_act_d;
      flush_start_q <= flush_start_d;
      exp_act_q     <= exp_act_d;
      exp_flash_q   <= exp_flash_d;
      exp_cnt_q     <= exp_cnt_d;
      nvm_full_q    <= nvm_full_d;
    end
  end

  assign flags_o.flush_wanted = (CFG_W'(fill_q) >= thresh_q) && !nvm_full_q && !reserved;
  assign flags_o.ram_count    = 7'(fill_q);
  assign flags_o.storage_full = nvm_full_q;
  assign flags_o.size         = size;

endmodule

// File: src/log_ring_with_flush_and_export.sv
// ----------------------------------------------------------------------------
// Log ring with flush and export
// Overwriting log ring in a RAM with flush and export reservations.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_if (push, flush start/done, export begin/commit/abort)
//   and are accepted when valid and ready are both high. Results leave on
//   out_if; every request gives one result, except a granted flush start and an
//   export begin that reads from the ring, which give one result per emitted
//   entry, the final one carrying last.
//   Configuration is written on cfg_we_i/cfg_idx_i/cfg_data_i while the block
//   is idle; writing the ring size empties the ring.
//   A one-result request passes through the single state, which loads its
//   result into the output register once that is free. A request emitting
//   N entries reads them in order from the single RAM read port, one per
//   cycle while the receiver keeps up; ready stays low until the last is loaded.
//   The output register holds a result while the receiver stalls; the RAM
//   read data is held as a second stage, so no entry is lost or repeated.
//   Reset empties the ring, clears both reservations and the storage-full
//   flag, and restores the default size, threshold and batch. RAM contents
//   are not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
module log_ring_with_flush_and_export (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lrfe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lrfe_pkg::CFG_W-1:0]     cfg_data_i,
  lrfe_in_if.sink                        in_if,
  lrfe_out_if.source                     out_if
);
  import lrfe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SINGLE = 3'b010,
    S_EMIT   = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [2:0]       status_q, status_d;
  logic             retry_q, retry_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             rd_pending_q, rd_pending_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_data_q, out_data_d;

  logic                   accept;
  logic                   out_free;
  logic                   move;
  logic                   issue;
  logic                   single_load;
  cmd_t                   cmd;
  flags_t                 flags;
  ram_wr_t                wr;
  logic [ENTRY_WIDTH-1:0] rd_data;

  assign in_if.ready = (state_q == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;

  lrfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .item_i     (in_if.data),
    .cmd_o      (cmd),
    .flags_o    (flags),
    .wr_o       (wr)
  );

  lrfe_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (issue),
    .raddr_i (ptr_q),
    .rdata_o (rd_data)
  );

  assign out_free    = !out_valid_q || out_if.ready;
  assign move        = (state_q == S_EMIT) && rd_pending_q && out_free;
  // A new read may replace the held read data only as it moves on.
  assign issue       = (state_q == S_EMIT) && (cnt_q != '0) && (!rd_pending_q || move);
  assign single_load = (state_q == S_SINGLE) && out_free;

  always_comb begin
    state_d      = state_q;
    status_d     = status_q;
    retry_d      = retry_q;
    ptr_d        = ptr_q;
    cnt_d        = cnt_q;
    rd_pending_d = rd_pending_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;

    if (out_if.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          retry_d  = cmd.retry;
          status_d = cmd.status;
          ptr_d    = cmd.start_ptr;
          cnt_d    = cmd.count;
          state_d  = cmd.emit ? S_EMIT : S_SINGLE;
        end
      end
      S_SINGLE: begin
        if (single_load) begin
          out_valid_d             = 1'b1;
          out_data_d.status       = status_q;
          out_data_d.out_entry    = '0;
          out_data_d.entry_valid  = 1'b0;
          out_data_d.last         = 1'b1;
          out_data_d.flush_wanted = flags.flush_wanted;
          out_data_d.retry_later  = retry_q;
          out_data_d.ram_count    = flags.ram_count;
          out_data_d.storage_full = flags.storage_full;
          state_d                 = S_IDLE;
        end
      end
      S_EMIT: begin
        if (issue) begin
          ptr_d        = adv_ptr(ptr_q, CNT_W'(1), flags.size);
          cnt_d        = cnt_q - CNT_W'(1);
          rd_pending_d = 1'b1;
        end else if (move) begin
          rd_pending_d = 1'b0;
        end
        if (move) begin
          out_valid_d             = 1'b1;
          out_data_d.status       = ST_OK;
          out_data_d.out_entry    = 32'(rd_data);
          out_data_d.entry_valid  = 1'b1;
          out_data_d.last         = (cnt_q == '0);
          out_data_d.flush_wanted = flags.flush_wanted;
          out_data_d.retry_later  = 1'b0;
          out_data_d.ram_count    = flags.ram_count;
          out_data_d.storage_full = flags.storage_full;
          if (cnt_q == '0) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      rd_pending_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      rd_pending_q <= rd_pending_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    retry_q    <= retry_d;
    ptr_q      <= ptr_d;
    out_data_q <= out_data_d;
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;

  // An emitting request always has a read in flight or one left to issue.
  a_emit_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) && !rd_pending_q |-> (cnt_q != '0))
    else $error("emit state with nothing pending and nothing left to read");

  // No read data may be left behind once the block is ready for a request.
  a_idle_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !rd_pending_q)
    else $error("idle with ring read data still held");

  // Pushes and emission never share a cycle on the RAM.
  a_ram_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr.en && issue))
    else $error("RAM written and read in the same cycle");

  // The fill level never exceeds the RAM depth.
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags.ram_count <= 7'(DEPTH))
    else $error("fill level above ring depth");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log ring testbench
// Drives requests through the log ring under several register settings,
// keeps a cycle-free copy of the ring and its reservations to predict every
// result, and checks each result field by field under random idling on both
// channels.
// ----------------------------------------------------------------------------
module testbench;
  import lrfe_pkg::*;

  localparam logic [2:0] OP_UNDEFINED = 3'd6;
  localparam logic [1:0] SS_FAILED    = 2'd2;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 16;
  // Longest quiet stretch of a correct run is a sender gap plus a receiver
  // stall plus a register phase change.
  localparam int unsigned QUIET_LIMIT   = 1000;
  localparam int unsigned PRINT_LIMIT   = 40;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  lrfe_in_if  req_if ();
  lrfe_out_if res_if ();

  log_ring_with_flush_and_export dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (req_if),
    .out_if    (res_if)
  );

  // Shadow copy of the ring, its reservations and its registers.
  logic [ENTRY_WIDTH-1:0] ring_copy [DEPTH];
  logic [PTR_W-1:0]       rd_ptr       = '0;
  logic [PTR_W-1:0]       wr_ptr       = '0;
  logic [PTR_W-1:0]       flush_anchor = '0;
  int unsigned            fill         = 0;
  bit                     flush_held   = 1'b0;
  bit                     export_held  = 1'b0;
  bit                     export_flash = 1'b0;
  int unsigned            export_claim = 0;
  bit                     storage_full_flag = 1'b0;
  logic [CFG_W-1:0]       cfg_size   = RST_RING_SIZE;
  logic [CFG_W-1:0]       cfg_thresh = RST_FLUSH_THRESH;
  logic [CFG_W-1:0]       cfg_batch  = RST_FLUSH_BATCH;

  in_item_t  request_queue [$];
  out_item_t ring_results_due [$];
  out_item_t next_due;

  bit          quiet_tail = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned accepted_requests = 0;
  int unsigned checked_results = 0;
  int unsigned flush_batches = 0;
  int unsigned ring_exports = 0;
  int unsigned settings_used = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned ring_span();
    if (cfg_size == 0) return 1;
    if (cfg_size > DEPTH) return DEPTH;
    return cfg_size;
  endfunction

  function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] p,
                                                    input int unsigned n);
    return PTR_W'((p + n) % ring_span());
  endfunction

  function automatic logic [2:0] storage_fault(input logic [1:0] sstat);
    return (sstat == SS_NO_SPACE) ? ST_FULL : ST_STORAGE_ERR;
  endfunction

  function automatic out_item_t ring_result(input logic [2:0] st,
                                            input logic [31:0] entry,
                                            input logic valid);
    out_item_t r;
    r = '0;
    r.status      = st;
    r.entry_valid = valid;
    r.out_entry   = valid ? entry : '0;
    return r;
  endfunction

  // Works out the results of one accepted request and updates the shadow.
  task automatic ring_apply_request(input in_item_t req);
    out_item_t        fresh [$];
    out_item_t        r;
    logic [PTR_W-1:0] p;
    logic [2:0]       st;
    int unsigned      span;
    int unsigned      n;
    int               i;
    bit               retry;
    bit               want;
    span  = ring_span();
    retry = 1'b0;
    case (req.op)
      OP_PUSH: begin
        if (fill >= span && (export_held || flush_held)) begin
          fresh.push_back(ring_result(ST_DROPPED, '0, 1'b0));
        end else begin
          ring_copy[wr_ptr] = req.entry_data;
          wr_ptr = ring_advance(wr_ptr, 1);
          if (fill >= span) rd_ptr = ring_advance(rd_ptr, 1);
          else fill++;
          fresh.push_back(ring_result(ST_OK, '0, 1'b0));
        end
      end
      OP_FLUSH_START: begin
        if (flush_held || export_held) begin
          fresh.push_back(ring_result(ST_BUSY, '0, 1'b0));
        end else if (cfg_batch == 0 || fill < cfg_thresh || fill < cfg_batch) begin
          fresh.push_back(ring_result(ST_NOT_READY, '0, 1'b0));
        end else begin
          p = rd_ptr;
          for (i = 0; i < int'(cfg_batch); i++) begin
            fresh.push_back(ring_result(ST_OK, ring_copy[p], 1'b1));
            p = ring_advance(p, 1);
          end
          flush_held   = 1'b1;
          flush_anchor = rd_ptr;
          flush_batches++;
        end
      end
      OP_FLUSH_DONE: begin
        if (!flush_held) begin
          fresh.push_back(ring_result(ST_INVALID, '0, 1'b0));
        end else begin
          if (req.storage_status == SS_OK) begin
            // The batch retires only if the ring still starts where it did.
            if (rd_ptr == flush_anchor && fill >= cfg_batch) begin
              rd_ptr = ring_advance(rd_ptr, cfg_batch);
              fill -= cfg_batch;
              fresh.push_back(ring_result(ST_OK, '0, 1'b0));
            end else begin
              fresh.push_back(ring_result(ST_IO, '0, 1'b0));
            end
          end else if (req.storage_status == SS_NO_SPACE) begin
            storage_full_flag = 1'b1;
            fresh.push_back(ring_result(ST_FULL, '0, 1'b0));
          end else begin
            retry = 1'b1;
            fresh.push_back(ring_result(ST_STORAGE_ERR, '0, 1'b0));
          end
          flush_held = 1'b0;
        end
      end
      OP_EXPORT_BEGIN: begin
        if (req.capacity_entries == 0) begin
          fresh.push_back(ring_result(ST_OK, '0, 1'b0));
        end else if (req.storage_status != SS_OK) begin
          fresh.push_back(ring_result(storage_fault(req.storage_status), '0, 1'b0));
        end else if (export_held || flush_held) begin
          fresh.push_back(ring_result(ST_BUSY, '0, 1'b0));
        end else if (req.flash_has_entries) begin
          n = (req.flash_entries < req.capacity_entries) ? req.flash_entries
                                                         : req.capacity_entries;
          if (n == 0) begin
            fresh.push_back(ring_result(ST_IO, '0, 1'b0));
          end else begin
            export_held  = 1'b1;
            export_flash = 1'b1;
            export_claim = n;
            fresh.push_back(ring_result(ST_OK, '0, 1'b0));
          end
        end else begin
          n = (fill < req.capacity_entries) ? fill : req.capacity_entries;
          if (n == 0) begin
            fresh.push_back(ring_result(ST_OK, '0, 1'b0));
          end else begin
            p = rd_ptr;
            for (i = 0; i < int'(n); i++) begin
              fresh.push_back(ring_result(ST_OK, ring_copy[p], 1'b1));
              p = ring_advance(p, 1);
            end
            export_held  = 1'b1;
            export_flash = 1'b0;
            export_claim = n;
            ring_exports++;
          end
        end
      end
      OP_EXPORT_COMMIT: begin
        st = ST_OK;
        if (!export_held) begin
          st = ST_INVALID;
        end else if (export_flash) begin
          if (req.storage_status != SS_OK) st = storage_fault(req.storage_status);
          else if (req.block_freed) storage_full_flag = 1'b0;
        end else if (export_claim <= fill) begin
          rd_ptr = ring_advance(rd_ptr, export_claim);
          fill -= export_claim;
        end else begin
          st = ST_INVALID;
        end
        export_held  = 1'b0;
        export_flash = 1'b0;
        export_claim = 0;
        fresh.push_back(ring_result(st, '0, 1'b0));
      end
      OP_EXPORT_ABORT: begin
        export_held  = 1'b0;
        export_flash = 1'b0;
        export_claim = 0;
        fresh.push_back(ring_result(ST_OK, '0, 1'b0));
      end
      default: begin
        fresh.push_back(ring_result(ST_INVALID, '0, 1'b0));
      end
    endcase
    want = fill >= cfg_thresh && !storage_full_flag && !flush_held && !export_held;
    for (i = 0; i < fresh.size(); i++) begin
      r = fresh[i];
      r.last         = (i == fresh.size() - 1);
      r.flush_wanted = want;
      r.retry_later  = retry;
      r.ram_count    = 7'(fill);
      r.storage_full = storage_full_flag;
      ring_results_due.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("mismatch at result %0d: %s is 0x%0h, expected 0x%0h",
               checked_results, what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic in_item_t random_request();
    in_item_t r;
    r.op                = 3'($urandom_range(0, 7));
    r.entry_data        = $urandom;
    r.storage_status    = 2'($urandom_range(0, 3));
    r.flash_has_entries = 1'($urandom_range(0, 1));
    r.flash_entries     = 10'($urandom_range(0, 1023));
    r.capacity_entries  = 10'($urandom_range(0, 1023));
    r.block_freed       = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic queue_request(input logic [2:0] op, input logic [1:0] sstat,
                               input logic [9:0] cap, input logic from_flash,
                               input logic [9:0] flash_n, input logic retired,
                               input logic [31:0] entry);
    in_item_t r;
    r.op                = op;
    r.entry_data        = entry;
    r.storage_status    = sstat;
    r.flash_has_entries = from_flash;
    r.flash_entries     = flash_n;
    r.capacity_entries  = cap;
    r.block_freed       = retired;
    request_queue.push_back(r);
  endtask

  // Mostly well-formed push bursts, flush rounds and export rounds with
  // random content, plus some fully random requests.
  task automatic add_random_mix(input int unsigned count);
    in_item_t    r;
    int unsigned added;
    int unsigned roll;
    int unsigned burst;
    added = 0;
    while (added < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        burst = $urandom_range(1, 6);
        repeat (burst) begin
          r = random_request();
          r.op = OP_PUSH;
          request_queue.push_back(r);
        end
        added += burst;
      end else if (roll < 60) begin
        r = random_request();
        r.op = OP_FLUSH_START;
        request_queue.push_back(r);
        burst = $urandom_range(0, 2);
        repeat (burst) begin
          r = random_request();
          r.op = OP_PUSH;
          request_queue.push_back(r);
        end
        r = random_request();
        r.op = OP_FLUSH_DONE;
        r.storage_status = ($urandom_range(0, 9) < 7) ? SS_OK : 2'($urandom_range(1, 3));
        request_queue.push_back(r);
        added += burst + 2;
      end else if (roll < 85) begin
        r = random_request();
        r.op = OP_EXPORT_BEGIN;
        r.storage_status = SS_OK;
        r.flash_has_entries = ($urandom_range(0, 9) < 3);
        if (r.flash_has_entries) r.flash_entries = 10'($urandom_range(1, 1023));
        r.capacity_entries = $urandom_range(0, 1) ? 10'($urandom_range(1, 8))
                                                  : 10'($urandom_range(1, 1023));
        request_queue.push_back(r);
        burst = $urandom_range(0, 2);
        repeat (burst) begin
          r = random_request();
          r.op = OP_PUSH;
          request_queue.push_back(r);
        end
        r = random_request();
        r.op = ($urandom_range(0, 3) == 0) ? OP_EXPORT_ABORT : OP_EXPORT_COMMIT;
        r.storage_status = ($urandom_range(0, 9) < 8) ? SS_OK : 2'($urandom_range(1, 3));
        request_queue.push_back(r);
        added += burst + 2;
      end else begin
        request_queue.push_back(random_request());
        added++;
      end
    end
  endtask

  // Waits until the block has nothing in flight, then writes all registers.
  task automatic start_phase(input logic [CFG_W-1:0] size,
                             input logic [CFG_W-1:0] thresh,
                             input logic [CFG_W-1:0] batch);
    while (request_queue.size() != 0 || req_if.valid || ring_results_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_RING_SIZE;
    cfg_data_i <= size;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_FLUSH_THRESH;
    cfg_data_i <= thresh;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_FLUSH_BATCH;
    cfg_data_i <= batch;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    // Writing the ring size empties the ring.
    cfg_size     = size;
    cfg_thresh   = thresh;
    cfg_batch    = batch;
    rd_ptr       = '0;
    wr_ptr       = '0;
    flush_anchor = '0;
    fill         = 0;
    settings_used++;
    @(negedge clk_i);
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      send_gap     <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        ring_apply_request(req_if.data);
        accepted_requests++;
      end
      if (!(req_if.valid && !req_if.ready)) begin
        if (send_gap != 0) begin
          send_gap     <= send_gap - 1;
          req_if.valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
          send_gap     <= $urandom_range(0, 9);
          req_if.valid <= 1'b0;
        end else if (request_queue.size() != 0) begin
          req_if.valid <= 1'b1;
          req_if.data  <= request_queue.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_stall   <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (ring_results_due.size() == 0) begin
          report_mismatch("status of a result with nothing due", 32'(res_if.data.status), '0);
        end else begin
          next_due = ring_results_due.pop_front();
          if (res_if.data.status !== next_due.status)
            report_mismatch("status", 32'(res_if.data.status), 32'(next_due.status));
          if (res_if.data.out_entry !== next_due.out_entry)
            report_mismatch("out_entry", res_if.data.out_entry, next_due.out_entry);
          if (res_if.data.entry_valid !== next_due.entry_valid)
            report_mismatch("entry_valid", 32'(res_if.data.entry_valid),
                            32'(next_due.entry_valid));
          if (res_if.data.last !== next_due.last)
            report_mismatch("last", 32'(res_if.data.last), 32'(next_due.last));
          if (res_if.data.flush_wanted !== next_due.flush_wanted)
            report_mismatch("flush_wanted", 32'(res_if.data.flush_wanted),
                            32'(next_due.flush_wanted));
          if (res_if.data.retry_later !== next_due.retry_later)
            report_mismatch("retry_later", 32'(res_if.data.retry_later),
                            32'(next_due.retry_later));
          if (res_if.data.ram_count !== next_due.ram_count)
            report_mismatch("ram_count", 32'(res_if.data.ram_count),
                            32'(next_due.ram_count));
          if (res_if.data.storage_full !== next_due.storage_full)
            report_mismatch("storage_full", 32'(res_if.data.storage_full),
                            32'(next_due.storage_full));
        end
        checked_results++;
      end
      if (recv_stall != 0) begin
        recv_stall   <= recv_stall - 1;
        res_if.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        recv_stall   <= $urandom_range(0, 9);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned sz;
    int unsigned th;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_RING_SIZE;
    cfg_data_i   = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    res_if.ready = 1'b0;
    for (int i = 0; i < DEPTH; i++) ring_copy[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on a two-entry ring.
    start_phase(7'd2, 7'd2, 7'd2);
    queue_request(OP_UNDEFINED, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_FLUSH_DONE, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_EXPORT_COMMIT, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_EXPORT_BEGIN, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_EXPORT_BEGIN, SS_NO_SPACE, 10'd5, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_EXPORT_BEGIN, SS_OK, 10'd5, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_FLUSH_START, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_PUSH, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0000_0000);
    queue_request(OP_PUSH, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'hFFFF_FFFF);
    // The ring is full here, so this push overwrites the oldest entry.
    queue_request(OP_PUSH, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h5A5A_0F0F);
    queue_request(OP_FLUSH_START, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_FLUSH_START, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_EXPORT_BEGIN, SS_OK, 10'd3, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_PUSH, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h1234_5678);
    queue_request(OP_FLUSH_DONE, SS_FAILED, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_FLUSH_START, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_FLUSH_DONE, SS_NO_SPACE, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_EXPORT_BEGIN, SS_OK, 10'd10, 1'b1, 10'd0, 1'b0, 32'h0);
    queue_request(OP_EXPORT_BEGIN, SS_OK, 10'd1023, 1'b1, 10'd1023, 1'b0, 32'h0);
    queue_request(OP_EXPORT_COMMIT, SS_OK, 10'd0, 1'b0, 10'd0, 1'b1, 32'h0);
    queue_request(OP_EXPORT_BEGIN, SS_OK, 10'd1, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_EXPORT_ABORT, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_EXPORT_BEGIN, SS_OK, 10'd1023, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_EXPORT_COMMIT, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_PUSH, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'hA5A5_F0F0);
    queue_request(OP_PUSH, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0F0F_5A5A);
    // Left open on purpose: the next size write empties the ring under it.
    queue_request(OP_FLUSH_START, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0);

    start_phase(7'd1, 7'd1, 7'd1);
    queue_request(OP_FLUSH_DONE, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0);
    add_random_mix(5);

    start_phase(7'd8, 7'd5, 7'd3);
    add_random_mix(10);
    queue_request(OP_EXPORT_ABORT, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_FLUSH_DONE, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_PUSH, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, $urandom);
    queue_request(OP_EXPORT_BEGIN, SS_OK, 10'd1023, 1'b0, 10'd0, 1'b0, 32'h0);

    // The claim now exceeds the emptied ring, so the commit is refused.
    start_phase(7'd0, 7'd0, 7'd0);
    queue_request(OP_EXPORT_COMMIT, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0);
    add_random_mix(4);

    // Full-size ring and the largest flush batch.
    start_phase(7'd64, 7'd64, 7'd64);
    repeat (65) queue_request(OP_PUSH, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, $urandom);
    queue_request(OP_FLUSH_START, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_FLUSH_DONE, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0);
    repeat (2) queue_request(OP_PUSH, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, $urandom);
    queue_request(OP_EXPORT_BEGIN, SS_OK, 10'd1023, 1'b0, 10'd0, 1'b0, 32'h0);
    queue_request(OP_EXPORT_COMMIT, SS_OK, 10'd0, 1'b0, 10'd0, 1'b0, 32'h0);

    start_phase(7'd127, 7'd127, 7'd127);
    add_random_mix(4);

    quiet_tail = 1'b1;
    sz = $urandom_range(2, 16);
    th = $urandom_range(1, sz);
    start_phase(7'(sz), 7'(th), 7'($urandom_range(1, th)));
    add_random_mix(8);

    while (request_queue.size() != 0 || req_if.valid || ring_results_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests and %0d results over %0d register settings.",
             accepted_requests, checked_results, settings_used);
    $display("Saw %0d flush batches and %0d exports from the ring; %0d mismatches.",
             flush_batches, ring_exports, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
